### sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, status codes and register indexes of the block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_BLOCKS = 4096;
  localparam int WORD_BITS  = 64;
  localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int BLOCK_W    = 12;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int ADDR_W     = $clog2(MAP_WORDS);
  localparam int TOTAL_W    = 13;
  localparam int CFG_W      = 13;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [BLOCK_W-1:0]   block_t;
  typedef logic [1:0]           status_t;

  localparam status_t ST_OK           = 2'd0;
  localparam status_t ST_FULL         = 2'd1;
  localparam status_t ST_ALREADY_FREE = 2'd2;
  localparam status_t ST_BAD_BLOCK    = 2'd3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic CFG_TOTAL_BLOCKS     = 1'b0;
  localparam logic CFG_FIRST_DATA_BLOCK = 1'b1;

  function automatic logic [BIT_W-1:0] first_set(input word_t v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

### sv/bba_map_ram.sv
// ----------------------------------------------------------------------------
// bba_map_ram
// Bitmap word memory, one read and one write port, registered read data.
// Per-word valid bits make unwritten words read as zero after reset.
// ----------------------------------------------------------------------------
module bba_map_ram (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  bba_pkg::addr_t rd_addr,
  output bba_pkg::word_t rd_data,
  input  logic          wr_en,
  input  bba_pkg::addr_t wr_addr,
  input  bba_pkg::word_t wr_data
);
  import bba_pkg::*;

  word_t                mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_r;
  word_t                q_r;
  logic                 q_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (rd_en) q_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

### sv/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a free-space bitmap held in a word memory.
// Sequence: S_IDLE takes a request and reads its first bitmap word, S_EVAL
// checks it (an allocate reads one 64-bit bitmap word per cycle), S_DONE
// loads the output; a new request is taken only once back in S_IDLE.
// Reset: synchronous; bitmap reads as all free, registers reset to defaults.
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_action,
  input  bba_pkg::block_t              in_block_number,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bba_pkg::block_t              out_granted_block,
  output bba_pkg::status_t             out_status,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]    cfg_wdata
);
  import bba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [TOTAL_W-1:0]   total_r;
  block_t               fdb_r;
  logic                 act_r, act_nxt;
  block_t               blk_r, blk_nxt;
  logic                 bad_r, bad_nxt;
  addr_t                word_r, word_nxt;
  block_t               res_blk_r, res_blk_nxt;
  status_t              res_st_r, res_st_nxt;
  logic                 out_valid_r, out_valid_nxt;
  block_t               out_blk_r, out_blk_nxt;
  status_t              out_st_r, out_st_nxt;

  logic [TOTAL_W-1:0]   limit;
  addr_t                last_w;
  logic                 accept, out_free;
  logic                 rd_en, wr_en;
  addr_t                rd_addr, wr_addr;
  word_t                rd_data, wr_data;
  word_t                lo_mask, hi_mask, free_bits;
  logic [BIT_W-1:0]     hit_idx;
  logic [ADDR_W:0]      limit_w;

  bba_map_ram u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign limit    = (total_r > TOTAL_W'(MAX_BLOCKS)) ? TOTAL_W'(MAX_BLOCKS) : total_r;
  assign limit_w  = limit[TOTAL_W-1:BIT_W];
  assign last_w   = (limit == '0) ? '0 : addr_t'((limit - TOTAL_W'(1)) >> BIT_W);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // mask of bits in the current word that lie inside the data range
  always_comb begin
    if (word_r > fdb_r[BLOCK_W-1:BIT_W]) begin
      lo_mask = '1;
    end else if (word_r == fdb_r[BLOCK_W-1:BIT_W]) begin
      lo_mask = {WORD_BITS{1'b1}} << fdb_r[BIT_W-1:0];
    end else begin
      lo_mask = '0;
    end
    if ({1'b0, word_r} < limit_w) begin
      hi_mask = '1;
    end else if ({1'b0, word_r} == limit_w) begin
      hi_mask = ~({WORD_BITS{1'b1}} << limit[BIT_W-1:0]);
    end else begin
      hi_mask = '0;
    end
  end

  assign free_bits = ~rd_data & lo_mask & hi_mask;
  assign hit_idx   = first_set(free_bits);

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    blk_nxt       = blk_r;
    bad_nxt       = bad_r;
    word_nxt      = word_r;
    res_blk_nxt   = res_blk_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_blk_nxt   = out_blk_r;
    out_st_nxt    = out_st_r;
    rd_en         = 1'b0;
    rd_addr       = word_r;
    wr_en         = 1'b0;
    wr_addr       = word_r;
    wr_data       = rd_data;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt   = in_action;
          blk_nxt   = in_block_number;
          bad_nxt   = ({1'b0, in_block_number} >= limit) || (in_block_number < fdb_r);
          word_nxt  = (in_action == ACT_FREE) ? in_block_number[BLOCK_W-1:BIT_W]
                                              : fdb_r[BLOCK_W-1:BIT_W];
          rd_en     = 1'b1;
          rd_addr   = word_nxt;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (act_r == ACT_FREE) begin
          res_blk_nxt = blk_r;
          state_nxt   = S_DONE;
          if (bad_r) begin
            res_st_nxt = ST_BAD_BLOCK;
          end else if (!rd_data[blk_r[BIT_W-1:0]]) begin
            res_st_nxt = ST_ALREADY_FREE;
          end else begin
            res_st_nxt = ST_OK;
            wr_en      = 1'b1;
            wr_data    = rd_data & ~(word_t'(1) << blk_r[BIT_W-1:0]);
          end
        end else if (|free_bits) begin
          res_blk_nxt = {word_r, hit_idx};
          res_st_nxt  = ST_OK;
          wr_en       = 1'b1;
          wr_data     = rd_data | (word_t'(1) << hit_idx);
          state_nxt   = S_DONE;
        end else if (word_r >= last_w) begin
          res_blk_nxt = '0;
          res_st_nxt  = ST_FULL;
          state_nxt   = S_DONE;
        end else begin
          // next word read overlaps the evaluation of this one
          word_nxt = word_r + addr_t'(1);
          rd_en    = 1'b1;
          rd_addr  = word_nxt;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_blk_nxt   = res_blk_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= TOTAL_W'(MAX_BLOCKS);
      fdb_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOTAL_BLOCKS:     total_r <= cfg_wdata[TOTAL_W-1:0];
          CFG_FIRST_DATA_BLOCK: fdb_r   <= cfg_wdata[BLOCK_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    blk_r     <= blk_nxt;
    bad_r     <= bad_nxt;
    word_r    <= word_nxt;
    res_blk_r <= res_blk_nxt;
    res_st_r  <= res_st_nxt;
    out_blk_r <= out_blk_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_granted_block = out_blk_r;
  assign out_status        = out_st_r;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap block allocator. A short list of
// directed requests and register writes exercises the edges first: an empty
// map, a full map, oversized and zero block counts, a reserved region
// covering everything, and bad or double frees. Randomized phases follow,
// each under its own register setting. Every accepted request runs through
// an in-bench bitmap that predicts the grant and status. Each result is
// checked in order against the prediction or a directed row's typed value.
// ----------------------------------------------------------------------------
module tb_top;
  import bba_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_PHASES  = 8;

  typedef struct packed {
    block_t  blk;
    status_t st;
  } grant_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic             act;
    logic             reg_idx;
    logic [CFG_W-1:0] arg;
    bit               typed;
    grant_t           want;
  } step_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_action = ACT_ALLOC;
  block_t           in_block_number = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  block_t           out_granted_block;
  status_t          out_status;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_TOTAL_BLOCKS;
  logic [CFG_W-1:0] cfg_wdata = '0;

  bitmap_block_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_block_number  (in_block_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_block(out_granted_block),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // bench copy of the bitmap and registers
  bit                 used_bits [MAX_BLOCKS];
  logic [TOTAL_W-1:0] m_total = 13'd4096;
  block_t             m_first = '0;

  grant_t    pending_results[$];
  step_row_t steps[$];
  int        errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        st_count[4] = '{0, 0, 0, 0};
  int        cycles = 0;
  bit        quiet = 1'b0;
  bit        hold_pending = 1'b0;

  int ph_total[NUM_PHASES] = '{64, 130, 4096, 8191, 1, 0, 0, 4096};
  int ph_first[NUM_PHASES] = '{0, 60, 3968, 4000, 0, 0, 0, 0};
  int ph_alloc[NUM_PHASES] = '{70, 55, 60, 50, 50, 50, 60, 55};
  int ph_items[NUM_PHASES] = '{85, 85, 85, 85, 80, 20, 85, 85};

  function automatic int block_limit();
    return (int'(m_total) > MAX_BLOCKS) ? MAX_BLOCKS : int'(m_total);
  endfunction

  function automatic grant_t apply_request(input logic act, input block_t blk);
    grant_t g;
    int     lim;
    lim  = block_limit();
    g.blk = '0;
    g.st  = ST_FULL;
    if (act == ACT_ALLOC) begin
      for (int b = int'(m_first); b < lim; b++) begin
        if (!used_bits[b]) begin
          used_bits[b] = 1'b1;
          g.blk = block_t'(b);
          g.st  = ST_OK;
          break;
        end
      end
    end else begin
      g.blk = blk;
      if (int'(blk) >= lim || blk < m_first) begin
        g.st = ST_BAD_BLOCK;
      end else if (!used_bits[blk]) begin
        g.st = ST_ALREADY_FREE;
      end else begin
        used_bits[blk] = 1'b0;
        g.st = ST_OK;
      end
    end
    return g;
  endfunction

  function automatic void add_req(input logic act, input block_t blk, input bit typed,
                                  input block_t eb, input status_t es);
    step_row_t r;
    r.kind    = ROW_REQ;
    r.act     = act;
    r.reg_idx = CFG_TOTAL_BLOCKS;
    r.arg     = CFG_W'(blk);
    r.typed   = typed;
    r.want    = '{blk: eb, st: es};
    steps.push_back(r);
  endfunction

  function automatic void add_cfg(input logic idx, input int val);
    step_row_t r;
    r.kind    = ROW_CFG;
    r.act     = ACT_ALLOC;
    r.reg_idx = idx;
    r.arg     = CFG_W'(val);
    r.typed   = 1'b0;
    r.want    = '0;
    steps.push_back(r);
  endfunction

  task automatic send_request(input logic act, input block_t blk, input bit typed,
                              input grant_t typed_res);
    grant_t g;
    @(negedge clk);
    in_valid        <= 1'b1;
    in_action       <= act;
    in_block_number <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = apply_request(act, blk);
    pending_results.push_back(typed ? typed_res : g);
    n_sent++;
  endtask

  task automatic idle_gap();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 50);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drain all outstanding results before touching the registers
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TOTAL_BLOCKS) m_total = val;
    else m_first = val[BLOCK_W-1:0];
  endtask

  task automatic random_request(input int alloc_pct);
    int     lim;
    int     r;
    int     cand[$];
    logic   act;
    block_t blk;
    lim = block_limit();
    r   = $urandom_range(0, 99);
    blk = block_t'($urandom_range(0, MAX_BLOCKS - 1));
    act = ACT_FREE;
    if (r < alloc_pct) begin
      act = ACT_ALLOC;
    end else if (lim > int'(m_first)) begin
      if (r < alloc_pct + (100 - alloc_pct) * 3 / 4) begin
        for (int b = int'(m_first); b < lim; b++) begin
          if (used_bits[b]) cand.push_back(b);
        end
        if (cand.size() != 0) blk = block_t'(cand[$urandom_range(0, cand.size() - 1)]);
      end else if (r < 95) begin
        blk = block_t'($urandom_range(int'(m_first), lim - 1));
      end
    end
    send_request(act, blk, 1'b0, '0);
    idle_gap();
  endtask

  // receiver side: random stalls, one long hold-off on request
  initial begin : receiver
    int run;
    bit stalled;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        stalled = ($urandom_range(0, 99) < 30);
        if (!stalled) run = $urandom_range(1, 12);
        else if ($urandom_range(0, 9) == 0) run = $urandom_range(10, 40);
        else run = $urandom_range(1, 3);
        out_stall <= stalled;
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: block %0d status %0d", $time,
                 out_granted_block, out_status);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        st_count[want.st]++;
        if (out_granted_block !== want.blk) begin
          errors++;
          $display("%0t: granted_block expected %0d actual %0d", $time, want.blk,
                   out_granted_block);
        end
        if (out_status !== want.st) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.st, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               pending_results.size());
      $display("bitmap_block_allocator: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    foreach (used_bits[i]) used_bits[i] = 1'b0;

    // defaults after reset: 4096 blocks, nothing reserved
    add_req(ACT_ALLOC, 12'd0,    1'b1, 12'd0,    ST_OK);
    add_req(ACT_ALLOC, 12'd4095, 1'b0, 12'd0,    ST_OK);
    add_req(ACT_FREE,  12'd0,    1'b1, 12'd0,    ST_OK);
    add_req(ACT_FREE,  12'd0,    1'b1, 12'd0,    ST_ALREADY_FREE);
    add_req(ACT_FREE,  12'd4095, 1'b1, 12'd4095, ST_ALREADY_FREE);
    add_req(ACT_ALLOC, 12'd0,    1'b1, 12'd0,    ST_OK);
    // oversized count behaves as the full map
    add_cfg(CFG_TOTAL_BLOCKS, 8191);
    add_req(ACT_FREE,  12'd4095, 1'b1, 12'd4095, ST_ALREADY_FREE);
    add_req(ACT_ALLOC, 12'd0,    1'b0, 12'd0,    ST_OK);
    // zero count
    add_cfg(CFG_TOTAL_BLOCKS, 0);
    add_req(ACT_ALLOC, 12'd77,   1'b1, 12'd0,    ST_FULL);
    add_req(ACT_FREE,  12'd0,    1'b1, 12'd0,    ST_BAD_BLOCK);
    // only the top block is usable
    add_cfg(CFG_TOTAL_BLOCKS, 4096);
    add_cfg(CFG_FIRST_DATA_BLOCK, 4095);
    add_req(ACT_ALLOC, 12'd0,    1'b1, 12'd4095, ST_OK);
    add_req(ACT_ALLOC, 12'd0,    1'b1, 12'd0,    ST_FULL);
    add_req(ACT_FREE,  12'd4094, 1'b1, 12'd4094, ST_BAD_BLOCK);
    add_req(ACT_FREE,  12'd4095, 1'b1, 12'd4095, ST_OK);
    // reserved region above the count
    add_cfg(CFG_TOTAL_BLOCKS, 100);
    add_cfg(CFG_FIRST_DATA_BLOCK, 200);
    add_req(ACT_ALLOC, 12'd0,    1'b1, 12'd0,    ST_FULL);
    add_req(ACT_FREE,  12'd150,  1'b1, 12'd150,  ST_BAD_BLOCK);
    // tiny window fills up
    add_cfg(CFG_TOTAL_BLOCKS, 4);
    add_cfg(CFG_FIRST_DATA_BLOCK, 1);
    add_req(ACT_ALLOC, 12'd0,    1'b0, 12'd0,    ST_OK);
    add_req(ACT_ALLOC, 12'd0,    1'b1, 12'd0,    ST_FULL);
    add_req(ACT_FREE,  12'd4,    1'b1, 12'd4,    ST_BAD_BLOCK);
    add_req(ACT_FREE,  12'd1,    1'b1, 12'd1,    ST_OK);
    add_req(ACT_ALLOC, 12'd0,    1'b0, 12'd0,    ST_OK);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_CFG) begin
        settle();
        write_reg(steps[i].reg_idx, steps[i].arg);
      end else begin
        send_request(steps[i].act, steps[i].arg[BLOCK_W-1:0], steps[i].typed,
                     steps[i].want);
        idle_gap();
      end
    end

    ph_total[6] = $urandom_range(1, 300);
    ph_first[6] = $urandom_range(0, 320);
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(CFG_TOTAL_BLOCKS, CFG_W'(ph_total[p]));
      write_reg(CFG_FIRST_DATA_BLOCK, CFG_W'(ph_first[p]));
      quiet = (p == 4);
      // long receiver hold-off while requests keep coming
      if (p == 1) hold_pending = 1'b1;
      repeat (ph_items[p]) random_request(ph_alloc[p]);
    end
    quiet = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("%0d requests sent, %0d results checked over %0d randomized register phases",
             n_sent, n_checked, NUM_PHASES);
    $display("ok %0d, full %0d, already free %0d, out of range or reserved %0d",
             st_count[ST_OK], st_count[ST_FULL], st_count[ST_ALREADY_FREE],
             st_count[ST_BAD_BLOCK]);
    if (errors == 0) begin
      $display("bitmap_block_allocator: match");
    end else begin
      $display("bitmap_block_allocator: mismatch");
    end
    $finish;
  end

endmodule
